FILE: design/rse_pkg.sv
// Shared types and constants of the RV32I subset executor.
// Used by the front end, the queue, the back end and the top level.
`default_nettype none

package rse_pkg;

   // Data path and register file geometry
   localparam int XLEN      = 32;
   localparam int REG_COUNT = 34;
   localparam int REG_IDX_W = 6;
   localparam logic [XLEN-1:0] PC_STEP = 32'd4;

   // Action codes carried on the request tuser
   localparam int ACT_W = 3;
   localparam logic [ACT_W-1:0] ACT_ADDI = 3'd0;
   localparam logic [ACT_W-1:0] ACT_LD   = 3'd1;
   localparam logic [ACT_W-1:0] ACT_SD   = 3'd2;
   localparam logic [ACT_W-1:0] ACT_JALR = 3'd3;
   localparam logic [ACT_W-1:0] ACT_BNE  = 3'd4;
   localparam logic [ACT_W-1:0] ACT_BEQ  = 3'd5;
   localparam logic [ACT_W-1:0] ACT_JAL  = 3'd6;

   // Link register written by jal
   localparam logic [REG_IDX_W-1:0] LINK_REG = 6'd1;

   // Stream payload widths
   localparam int REQ_DATA_W = 88;
   localparam int RSP_DATA_W = 144;

   // Decoded control of one request
   typedef struct packed {
      logic                 addi;
      logic                 load;
      logic                 store;
      logic                 jalr;
      logic                 bne;
      logic                 beq;
      logic                 jal;
      logic                 unknown;
      logic                 wr_en;
      logic [REG_IDX_W-1:0] wr_idx;
   } ctrl_type;

   // One classified request as held in the queue
   typedef struct packed {
      ctrl_type             ctrl;
      logic [REG_IDX_W-1:0] src1;
      logic [REG_IDX_W-1:0] src2;
      logic [XLEN-1:0]      imm;
      logic [XLEN-1:0]      target;
   } queue_item_type;

   // Result of the execute stage, completed in the memory stage
   typedef struct packed {
      logic [XLEN-1:0]      item_pc;
      logic [XLEN-1:0]      next_pc;
      logic                 taken;
      logic                 wr_en;
      logic [REG_IDX_W-1:0] wr_idx;
      logic [XLEN-1:0]      value;
      logic                 mem_wr;
      logic [XLEN-1:0]      mem_addr;
      logic                 fault;
      logic                 unknown;
      logic                 load;
   } exec_type;

endpackage

`default_nettype wire

FILE: design/riscv_subset_executor.sv
// Top level of the RV32I subset executor: front end, request queue and back end.
// Depends on rse_pkg, rse_front, rse_fifo, rse_back and rse_ram.
//
//  Channel  | Direction | Ports                       | Payload
//  ---------+-----------+-----------------------------+--------------------------------
//  request  | in        | req_tvalid/tready/tdata/tuser | one decoded instruction
//  response | out       | rsp_tvalid/tready/tdata     | one execution record per request
//
// One request per cycle while the response is not stalled and memory is not clearing;
// responses leave the response register after queue, execute and memory access.
// The execute stage closes the loop through operand forwarding and the PC register.
// After reset the data memory is cleared one word a cycle, with req_tready low until
// the last word is cleared.
// A stalled response backs up the pipeline; the queue keeps taking requests until full.
`default_nettype none

module riscv_subset_executor
   import rse_pkg::*;
#(
   parameter int MEM_DEPTH   = 1024,
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // [5:0] dest_reg, [11:6] src1_reg, [17:12] src2_reg, [49:18] immediate,
   // [81:50] branch_target, [87:82] zero
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // [2:0] action
   input  wire logic [ACT_W-1:0]      req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [31:0] item_pc, [63:32] next_pc, [64] jump_taken, [65] reg_written,
   // [71:66] written_reg, [103:72] written_value, [104] mem_written,
   // [136:105] mem_address, [137] address_fault, [138] unknown_op, [143:139] zero
   output logic      [RSP_DATA_W-1:0] rsp_tdata
);

   logic           push, pop, full, head_valid, clearing;
   queue_item_type push_item, head_item;

   rse_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .queue_full (full),
      .clearing   (clearing),
      .push       (push),
      .push_item  (push_item)
   );

   rse_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .pop        (pop),
      .full       (full),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   rse_back #(
      .MEM_DEPTH (MEM_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (head_valid),
      .q_item     (head_item),
      .q_pop      (pop),
      .clearing   (clearing),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

FILE: design/rse_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module rse_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port; a same-edge read returns the old word
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

FILE: design/rse_fifo.sv
// Short request queue between the front end and the back end.
// Depends on rse_pkg for the queued item type.
`default_nettype none

module rse_fifo
   import rse_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           push,
   input  wire queue_item_type push_item,
   input  wire logic           pop,
   output logic                full,
   output logic                head_valid,
   output queue_item_type      head_item
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   queue_item_type    ent_ff [DEPTH];
   logic [PW-1:0]     wptr_ff, wptr_in;
   logic [PW-1:0]     rptr_ff, rptr_in;
   logic [CW-1:0]     cnt_ff, cnt_in;

   // Advance pointers and occupancy
   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      cnt_in  = cnt_ff;
      if (push) begin
         wptr_in = (wptr_ff == PW'(DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (pop) begin
         rptr_in = (rptr_ff == PW'(DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wptr_ff] <= push_item;
      end
   end

   assign full       = (cnt_ff == CW'(DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head_item  = ent_ff[rptr_ff];

endmodule

`default_nettype wire

FILE: design/rse_front.sv
// Front end: takes requests and classifies the action into control flags.
// Depends on rse_pkg for action codes and the queued item type.
`default_nettype none

module rse_front
   import rse_pkg::*;
(
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic [ACT_W-1:0]      req_tuser,
   input  wire logic                  queue_full,
   input  wire logic                  clearing,
   output logic                       push,
   output queue_item_type             push_item
);

   logic [REG_IDX_W-1:0] dest;
   ctrl_type             ctrl;

   assign dest = req_tdata[5:0];

   // Decode the action
   always_comb begin
      ctrl = '0;
      unique case (req_tuser)
         ACT_ADDI: ctrl.addi = 1'b1;
         ACT_LD:   ctrl.load = 1'b1;
         ACT_SD:   ctrl.store = 1'b1;
         ACT_JALR: ctrl.jalr = 1'b1;
         ACT_BNE:  ctrl.bne = 1'b1;
         ACT_BEQ:  ctrl.beq = 1'b1;
         ACT_JAL:  ctrl.jal = 1'b1;
         default:  ctrl.unknown = 1'b1;
      endcase
      // Resolve the destination; drop writes beyond the register file
      ctrl.wr_idx = ctrl.jal ? LINK_REG : dest;
      ctrl.wr_en  = (ctrl.addi | ctrl.load | ctrl.jalr | ctrl.jal) &&
                    (ctrl.wr_idx < REG_IDX_W'(REG_COUNT));
   end

   // Hold off requests while memory clears or the queue is full
   assign req_tready = !clearing && !queue_full;
   assign push       = req_tvalid && req_tready;

   assign push_item.ctrl   = ctrl;
   assign push_item.src1   = req_tdata[11:6];
   assign push_item.src2   = req_tdata[17:12];
   assign push_item.imm    = req_tdata[49:18];
   assign push_item.target = req_tdata[81:50];

endmodule

`default_nettype wire

FILE: design/rse_back.sv
// Back end: register read, execute, memory access, writeback and response register.
// Depends on rse_pkg and instantiates rse_ram for register file and data memory.
`default_nettype none

module rse_back
   import rse_pkg::*;
#(
   parameter int MEM_DEPTH = 1024
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  q_valid,
   input  wire queue_item_type        q_item,
   output logic                       q_pop,
   output logic                       clearing,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic      [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int AW = $clog2(MEM_DEPTH);
   localparam logic [XLEN-1:0] DEPTH_W = XLEN'(MEM_DEPTH);

   // Pipeline control
   logic           b_vld_ff, b_vld_in;
   queue_item_type b_item_ff;
   logic           c_vld_ff, c_vld_in;
   exec_type       c_ff;
   exec_type       c_done;
   logic           d_vld_ff, d_vld_in;
   exec_type       d_ff;
   logic           d_adv, c_fire, c_adv, b_fire, b_adv;

   // Program counter and clearing sweep
   logic [XLEN-1:0] pc_ff, pc_in;
   logic            clr_busy_ff, clr_busy_in;
   logic [AW-1:0]   clr_cnt_ff, clr_cnt_in;

   // Register file read and forwarding
   logic [REG_COUNT-1:0] reg_vld_ff;
   logic                 rd1_vld_ff, rd2_vld_ff;
   logic [REG_IDX_W-1:0] rs1_sel, rs2_sel, ra1, ra2;
   logic [XLEN-1:0]      rf1_data, rf2_data;
   logic                 lw_vld_ff;
   logic [REG_IDX_W-1:0] lw_idx_ff;
   logic [XLEN-1:0]      lw_val_ff;
   logic [XLEN-1:0]      c_value;
   logic [XLEN-1:0]      op_a, op_b;

   // Execute
   logic [XLEN-1:0] sum, seq;
   exec_type        b_res;

   // Data memory ports
   logic            dm_we;
   logic [AW-1:0]   dm_waddr;
   logic [XLEN-1:0] dm_wdata, dm_rdata;

   // Handshake chain from the response side back to the queue
   assign d_adv  = !d_vld_ff || rsp_tready;
   assign c_fire = c_vld_ff && d_adv;
   assign c_adv  = !c_vld_ff || c_fire;
   assign b_fire = b_vld_ff && c_adv;
   assign b_adv  = !b_vld_ff || b_fire;
   assign q_pop  = q_valid && b_adv && !clr_busy_ff;

   assign b_vld_in = b_adv ? q_pop : b_vld_ff;
   assign c_vld_in = c_adv ? b_fire : c_vld_ff;
   assign d_vld_in = d_adv ? c_fire : d_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
         d_vld_ff <= 1'b0;
      end else begin
         b_vld_ff <= b_vld_in;
         c_vld_ff <= c_vld_in;
         d_vld_ff <= d_vld_in;
      end
   end

   // Complete the memory stage record with the final value
   always_comb begin
      c_done       = c_ff;
      c_done.value = c_value;
   end

   // Stage payloads
   always_ff @(posedge clock) begin
      if (q_pop) begin
         b_item_ff <= q_item;
      end
      if (b_fire) begin
         c_ff <= b_res;
      end
      if (c_fire) begin
         d_ff <= c_done;
      end
   end

   // Clear data memory after reset, one word a cycle
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_cnt_in  = clr_cnt_ff;
      if (clr_busy_ff) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == AW'(MEM_DEPTH - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_cnt_ff  <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_cnt_ff  <= clr_cnt_in;
      end
   end

   assign clearing = clr_busy_ff;

   // Register read: fetch for the next item, or re-read for a stalled one
   assign rs1_sel = b_adv ? q_item.src1 : b_item_ff.src1;
   assign rs2_sel = b_adv ? q_item.src2 : b_item_ff.src2;
   assign ra1     = (rs1_sel < REG_IDX_W'(REG_COUNT)) ? rs1_sel : '0;
   assign ra2     = (rs2_sel < REG_IDX_W'(REG_COUNT)) ? rs2_sel : '0;

   rse_ram #(
      .WIDTH (XLEN),
      .DEPTH (REG_COUNT)
   ) u_rf1 (
      .clock (clock),
      .we    (c_fire && c_ff.wr_en),
      .waddr (c_ff.wr_idx),
      .wdata (c_value),
      .re    (1'b1),
      .raddr (ra1),
      .rdata (rf1_data)
   );

   rse_ram #(
      .WIDTH (XLEN),
      .DEPTH (REG_COUNT)
   ) u_rf2 (
      .clock (clock),
      .we    (c_fire && c_ff.wr_en),
      .waddr (c_ff.wr_idx),
      .wdata (c_value),
      .re    (1'b1),
      .raddr (ra2),
      .rdata (rf2_data)
   );

   // Written marks: an unwritten register reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         reg_vld_ff <= '0;
      end else if (c_fire && c_ff.wr_en) begin
         reg_vld_ff[c_ff.wr_idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      rd1_vld_ff <= reg_vld_ff[ra1];
      rd2_vld_ff <= reg_vld_ff[ra2];
   end

   // Track the most recent register write for forwarding
   always_ff @(posedge clock) begin
      if (reset) begin
         lw_vld_ff <= 1'b0;
      end else if (c_fire && c_ff.wr_en) begin
         lw_vld_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (c_fire && c_ff.wr_en) begin
         lw_idx_ff <= c_ff.wr_idx;
         lw_val_ff <= c_value;
      end
   end

   // Final value of the memory stage: a load takes memory data, zero on fault
   assign c_value = (c_ff.load && c_ff.wr_en) ? (c_ff.fault ? '0 : dm_rdata) : c_ff.value;

   // Operand A: zero for an out-of-range source, else pending write first, then last write, then register file
   always_comb begin
      if (b_item_ff.src1 >= REG_IDX_W'(REG_COUNT)) begin
         op_a = '0;
      end else if (c_vld_ff && c_ff.wr_en && (c_ff.wr_idx == b_item_ff.src1)) begin
         op_a = c_value;
      end else if (lw_vld_ff && (lw_idx_ff == b_item_ff.src1)) begin
         op_a = lw_val_ff;
      end else begin
         op_a = rd1_vld_ff ? rf1_data : '0;
      end
   end

   // Operand B, same priority
   always_comb begin
      if (b_item_ff.src2 >= REG_IDX_W'(REG_COUNT)) begin
         op_b = '0;
      end else if (c_vld_ff && c_ff.wr_en && (c_ff.wr_idx == b_item_ff.src2)) begin
         op_b = c_value;
      end else if (lw_vld_ff && (lw_idx_ff == b_item_ff.src2)) begin
         op_b = lw_val_ff;
      end else begin
         op_b = rd2_vld_ff ? rf2_data : '0;
      end
   end

   // Execute: address add, compare, next PC
   assign sum = op_a + b_item_ff.imm;
   assign seq = pc_ff + PC_STEP;

   always_comb begin
      ctrl_type ct;
      ct = b_item_ff.ctrl;
      b_res          = '0;
      b_res.item_pc  = pc_ff;
      b_res.wr_en    = ct.wr_en;
      b_res.wr_idx   = ct.wr_en ? ct.wr_idx : '0;
      b_res.unknown  = ct.unknown;
      b_res.load     = ct.load;
      b_res.taken    = ct.jalr || ct.jal ||
                       (ct.bne && (op_a != op_b)) ||
                       (ct.beq && (op_a == op_b));
      if (ct.jalr) begin
         b_res.next_pc = sum;
      end else if (b_res.taken) begin
         b_res.next_pc = b_item_ff.target;
      end else begin
         b_res.next_pc = seq;
      end
      if (ct.load || ct.store) begin
         b_res.mem_addr = sum;
         b_res.fault    = (sum >= DEPTH_W);
      end
      b_res.mem_wr = ct.store && !b_res.fault;
      if (ct.store) begin
         b_res.value = op_b;
      end else if (ct.wr_en) begin
         b_res.value = (ct.jalr || ct.jal) ? seq : sum;
      end
   end

   // Advance the program counter as each item executes
   assign pc_in = b_fire ? b_res.next_pc : pc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= '0;
      end else begin
         pc_ff <= pc_in;
      end
   end

   // Data memory: the clear sweep writes zeros, stores write in execute, loads read into the memory stage
   assign dm_we    = clr_busy_ff || (b_fire && b_res.mem_wr);
   assign dm_waddr = clr_busy_ff ? clr_cnt_ff : sum[AW-1:0];
   assign dm_wdata = clr_busy_ff ? '0 : op_b;

   rse_ram #(
      .WIDTH (XLEN),
      .DEPTH (MEM_DEPTH)
   ) u_dmem (
      .clock (clock),
      .we    (dm_we),
      .waddr (dm_waddr),
      .wdata (dm_wdata),
      .re    (b_fire),
      .raddr (sum[AW-1:0]),
      .rdata (dm_rdata)
   );

   // Response register
   assign rsp_tvalid = d_vld_ff;
   assign rsp_tdata  = {5'b0,
                        d_ff.unknown,
                        d_ff.fault,
                        d_ff.mem_addr,
                        d_ff.mem_wr,
                        d_ff.value,
                        d_ff.wr_idx,
                        d_ff.wr_en,
                        d_ff.taken,
                        d_ff.next_pc,
                        d_ff.item_pc};

endmodule

`default_nettype wire
